[sv/hnc_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the class decision for the heightfield normal classifier.
// No dependencies; the interfaces, the normaliser and the top level import this package.
package hnc_pkg;

   // Default grid limits, handed to the top level parameters
   localparam int MAX_COLS_DEF = 32;
   localparam int MAX_ROWS_DEF = 1024;

   // Field widths
   localparam int H_W     = 16;   // height, Q8.8 signed
   localparam int Q14_W   = 16;   // normal component, Q1.14 signed
   localparam int CLS_W   = 3;
   localparam int ROW_W   = 10;
   localparam int COL_W   = 5;
   localparam int ACC_W   = 20;   // per component accumulator
   localparam int VEC_W   = 34;   // face components are 17x17 signed products
   localparam int OUT_LIMIT = 64;

   // Configuration port
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 16;

   typedef enum logic [CSR_AW-1:0] {
      REG_GRID_COLS   = 3'd0,
      REG_STEP_X      = 3'd1,
      REG_STEP_Z      = 3'd2,
      REG_SLOPE_FLAT  = 3'd3,
      REG_SLOPE_EDGE  = 3'd4,
      REG_HEIGHT_LOW  = 3'd5,
      REG_HEIGHT_MID  = 3'd6,
      REG_HEIGHT_HIGH = 3'd7
   } reg_idx_type;

   // Register reset values
   localparam logic [5:0]        GRID_COLS_RST   = 6'd32;
   localparam logic [15:0]       STEP_X_RST      = 16'd256;
   localparam logic [15:0]       STEP_Z_RST      = 16'd256;
   localparam logic [14:0]       SLOPE_FLAT_RST  = 15'd11469;
   localparam logic [14:0]       SLOPE_EDGE_RST  = 15'd13107;
   localparam logic signed [15:0] HEIGHT_LOW_RST  = 16'sd589;
   localparam logic signed [15:0] HEIGHT_MID_RST  = 16'sd640;
   localparam logic signed [15:0] HEIGHT_HIGH_RST = 16'sd691;

   // Vertex classes
   localparam logic [CLS_W-1:0] CLS_GRASS      = 3'd0;
   localparam logic [CLS_W-1:0] CLS_DIRT       = 3'd1;
   localparam logic [CLS_W-1:0] CLS_EDGE_GRASS = 3'd2;
   localparam logic [CLS_W-1:0] CLS_EDGE_DIRT  = 3'd3;
   localparam logic [CLS_W-1:0] CLS_SNOW       = 3'd4;
   localparam logic [CLS_W-1:0] CLS_ROCK       = 3'd5;

   typedef logic signed [H_W-1:0]   height_type;
   typedef logic signed [Q14_W-1:0] q14_type;
   typedef logic signed [VEC_W-1:0] comp_type;
   typedef logic signed [ACC_W-1:0] acc_type;

   function automatic comp_type acc_to_comp(input acc_type a);
      return VEC_W'(a);
   endfunction

   function automatic logic [CLS_W-1:0] classify(
      input q14_type          ny,
      input height_type       h,
      input logic [14:0]      flat_lim,
      input logic [14:0]      slope_lim,
      input height_type       lo,
      input height_type       mid,
      input height_type       hi);
      logic [14:0]      s;
      logic [CLS_W-1:0] k;
      s = ny[Q14_W-1] ? 15'(-ny) : 15'(ny);
      if (!(s > flat_lim)) begin
         k = CLS_ROCK;
      end else begin
         k = (h < lo) ? CLS_GRASS : CLS_DIRT;
         if (h < mid && s < slope_lim)      k = CLS_EDGE_GRASS;
         else if (h < hi && s < slope_lim)  k = CLS_EDGE_DIRT;
         else if (h > mid)                  k = CLS_SNOW;
      end
      return k;
   endfunction

endpackage

[sv/hnc_if.sv]
`timescale 1ns / 1ps
// Valid/ready channels for height samples in and classified vertex normals out.
// Depends on hnc_pkg.
interface hnc_req_if;
   import hnc_pkg::*;
   logic       valid;
   logic       ready;
   height_type height;
   logic       last;
   modport source (output valid, height, last, input ready);
   modport sink   (input valid, height, last, output ready);
endinterface

interface hnc_rsp_if;
   import hnc_pkg::*;
   logic             valid;
   logic             ready;
   q14_type          normal_x;
   q14_type          normal_y;
   q14_type          normal_z;
   logic [CLS_W-1:0] vertex_class;
   logic [ROW_W-1:0] row;
   logic [COL_W-1:0] col;
   logic             last_out;
   modport source (output valid, normal_x, normal_y, normal_z, vertex_class, row, col,
                   last_out, input ready);
   modport sink   (input valid, normal_x, normal_y, normal_z, vertex_class, row, col,
                   last_out, output ready);
endinterface

[sv/hnc_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module hnc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule

[sv/hnc_norm.sv]
`timescale 1ns / 1ps
// Iterative vector normaliser: range shift, sum of squares, bit-pair square root and
// restoring division to Q1.14. Depends on hnc_pkg.
module hnc_norm (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  hnc_pkg::comp_type   vec_in [3],
   output logic                done,
   output hnc_pkg::q14_type    norm_out [3]
);
   import hnc_pkg::*;

   localparam int MAG_W = VEC_W - 1;
   localparam int NRM_W = 31;           // the largest magnitude lands in [2^30, 2^31)
   localparam int SQ_W  = 2 * NRM_W;
   localparam int SUM_W = 64;
   localparam int LEN_W = 32;
   localparam int FRAC  = 14;
   localparam int REM_W = NRM_W + FRAC + 1;
   localparam int QB_W  = FRAC + 1;

   typedef enum logic [2:0] {N_IDLE, N_SHIFT, N_SQ, N_SQRT, N_DLOAD, N_DIV} nstate_type;

   nstate_type           state_ff;
   logic [MAG_W-1:0]     a_ff [3];
   logic [2:0]           neg_ff;
   logic [1:0]           idx_ff;
   logic [SQ_W-1:0]      prod_ff;
   logic [SUM_W-1:0]     sum_ff;
   logic [SUM_W-1:0]     sv_ff;
   logic [SUM_W-1:0]     r_ff;
   logic [SUM_W-1:0]     b_ff;
   logic [4:0]           it_ff;
   logic [REM_W-1:0]     rem_ff;
   logic [REM_W-1:0]     dsh_ff;
   logic [QB_W-1:0]      q_ff;
   logic [3:0]           step_ff;
   logic                 done_ff;
   q14_type              out_ff [3];

   logic [MAG_W-1:0]     m01, m, a_sel;
   logic [SUM_W-1:0]     rb_in;
   logic                 sq_ge, div_ge;
   logic [QB_W-1:0]      q_in;
   q14_type              q16;
   logic [MAG_W-1:0]     mag_in [3];

   always_comb begin
      m01 = (a_ff[0] > a_ff[1]) ? a_ff[0] : a_ff[1];
      m   = (m01 > a_ff[2]) ? m01 : a_ff[2];
      case (idx_ff)
         2'd0:    a_sel = a_ff[0];
         2'd1:    a_sel = a_ff[1];
         default: a_sel = a_ff[2];
      endcase
      rb_in  = r_ff + b_ff;
      sq_ge  = sv_ff >= rb_in;
      div_ge = rem_ff >= dsh_ff;
      q_in   = {q_ff[QB_W-2:0], div_ge};
      q16    = Q14_W'(q_in);
      for (int i = 0; i < 3; i++) begin
         mag_in[i] = vec_in[i][VEC_W-1] ? MAG_W'(-vec_in[i]) : MAG_W'(vec_in[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            N_IDLE: begin
               if (start) begin
                  for (int i = 0; i < 3; i++) begin
                     a_ff[i]   <= mag_in[i];
                     neg_ff[i] <= vec_in[i][VEC_W-1];
                  end
                  state_ff <= N_SHIFT;
               end
            end
            N_SHIFT: begin
               if (m == '0) begin
                  for (int i = 0; i < 3; i++) out_ff[i] <= '0;
                  done_ff  <= 1'b1;
                  state_ff <= N_IDLE;
               end else if (m[MAG_W-1:NRM_W] != '0) begin
                  for (int i = 0; i < 3; i++) a_ff[i] <= a_ff[i] >> 1;
               end else if (!m[NRM_W-1]) begin
                  for (int i = 0; i < 3; i++) a_ff[i] <= a_ff[i] << 1;
               end else begin
                  idx_ff   <= 2'd0;
                  sum_ff   <= '0;
                  state_ff <= N_SQ;
               end
            end
            N_SQ: begin
               // product registered, summed in the next cycle
               prod_ff <= a_sel[NRM_W-1:0] * a_sel[NRM_W-1:0];
               if (idx_ff != 2'd0) sum_ff <= sum_ff + SUM_W'(prod_ff);
               idx_ff <= idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  sv_ff    <= sum_ff + SUM_W'(prod_ff);
                  r_ff     <= '0;
                  b_ff     <= SUM_W'(1) << (SUM_W - 2);
                  it_ff    <= '0;
                  state_ff <= N_SQRT;
               end
            end
            N_SQRT: begin
               if (sq_ge) begin
                  sv_ff <= sv_ff - rb_in;
                  r_ff  <= (r_ff >> 1) + b_ff;
               end else begin
                  r_ff <= r_ff >> 1;
               end
               b_ff  <= b_ff >> 2;
               it_ff <= it_ff + 5'd1;
               if (it_ff == 5'd31) begin
                  idx_ff   <= 2'd0;
                  state_ff <= N_DLOAD;
               end
            end
            N_DLOAD: begin
               // numerator a*2^14 + len/2, divisor aligned to the top quotient bit
               rem_ff   <= REM_W'({a_sel[NRM_W-1:0], FRAC'(0)}) + REM_W'(r_ff[LEN_W-1:1]);
               dsh_ff   <= {r_ff[LEN_W-1:0], FRAC'(0)};
               q_ff     <= '0;
               step_ff  <= '0;
               state_ff <= N_DIV;
            end
            N_DIV: begin
               if (div_ge) rem_ff <= rem_ff - dsh_ff;
               dsh_ff  <= dsh_ff >> 1;
               q_ff    <= q_in;
               step_ff <= step_ff + 4'd1;
               if (step_ff == 4'(FRAC)) begin
                  out_ff[idx_ff] <= neg_ff[idx_ff] ? -q16 : q16;
                  if (idx_ff == 2'd2) begin
                     done_ff  <= 1'b1;
                     state_ff <= N_IDLE;
                  end else begin
                     idx_ff   <= idx_ff + 2'd1;
                     state_ff <= N_DLOAD;
                  end
               end
            end
            default: state_ff <= N_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   always_comb begin
      for (int i = 0; i < 3; i++) norm_out[i] = out_ff[i];
   end
endmodule

[sv/heightfield_normal_classifier_core.sv]
`timescale 1ns / 1ps
// Top level: sequencer over the height line RAM and the accumulator RAM, one shared
// normaliser, configuration registers. Depends on hnc_pkg, hnc_if, hnc_ram, hnc_norm.
//
//  channel   dir  handshake            payload
//  req_ch    in   valid/ready          height, last
//  rsp_ch    out  valid/ready          normal_x/y/z, vertex_class, row, col, last_out
//  csr_*     in   csr_we (no stall)    csr_addr, csr_wdata
//
// One item at a time. A normalisation runs a range shift, the sum of squares, the
// square-root steps and one restoring divide per component. Each cell normalises
// two face vectors and each emitted vertex one accumulated vector in the normaliser.
// Reset is synchronous; accumulators read as zero through per-entry valid flops.
// A result waits in the output register while the next item is accepted; the
// sequencer only stalls when a further result meets a full output register.
module heightfield_normal_classifier_core
   import hnc_pkg::*;
#(
   parameter int MAX_COLS = MAX_COLS_DEF,
   parameter int MAX_ROWS = MAX_ROWS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   hnc_req_if.sink               req_ch,
   hnc_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_AW-1:0]     csr_addr,
   input  logic [CSR_DW-1:0]     csr_wdata
);
   import hnc_pkg::*;

   localparam int CW      = $clog2(MAX_COLS);
   localparam int RW      = $clog2(MAX_ROWS);
   localparam int AW      = CW + 1;
   localparam int DEPTH   = 2 ** AW;
   localparam int ACC_DW  = 3 * ACC_W;
   localparam int CNT_W   = $clog2(OUT_LIMIT + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_RD_TL, S_RD_TR, S_GET_TR, S_MUL, S_NSTART, S_NWAIT,
      S_ACC_RD, S_ACC_WR, S_EM_RD, S_EM_LD, S_EM_WAIT, S_EM_OUT, S_FIN
   } state_type;

   // configuration
   logic [5:0]  grid_cols_ff;
   logic [15:0] step_x_ff, step_z_ff;
   logic [14:0] slope_flat_ff, slope_edge_ff;
   height_type  height_low_ff, height_mid_ff, height_high_ff;

   // sequencer
   state_type                 state_ff;
   logic [CW-1:0]             col_ff, c_ff, k_ff, top_hi_ff;
   logic [RW-1:0]             row_ff;
   logic                      prev_valid_ff, sel_ff, last_ff, fi_ff, em_bot_ff;
   logic [1:0][MAX_COLS-1:0]  acc_vld_ff;
   logic [1:0]                ci_ff, ti_ff;
   logic [CNT_W-1:0]          em_cnt_ff;
   height_type                h_ff, bl_ff, tl_ff, tr_ff, eh_ff;
   comp_type                  f_ff [3];

   // result register
   logic                      rsp_valid_ff;
   q14_type                   rsp_nx_ff, rsp_ny_ff, rsp_nz_ff;
   logic [CLS_W-1:0]          rsp_cls_ff;
   logic [ROW_W-1:0]          rsp_row_ff;
   logic [COL_W-1:0]          rsp_col_ff;
   logic                      rsp_last_ff;

   logic                      accept, restart_req, has_cell, top_en_in;
   logic [CW-1:0]             cols_m1, c_in, top_hi_in, k_in;
   logic [RW-1:0]             prev_row;

   // memories
   logic                      h_we;
   logic [AW-1:0]             h_waddr, h_raddr;
   logic [H_W-1:0]            h_rdata;
   logic                      acc_we;
   logic [AW-1:0]             acc_raddr, acc_waddr;
   logic [ACC_DW-1:0]         acc_rdata, acc_wdata;

   logic                      tgt_top, tgt_line, em_line, tgt_vld, em_vld;
   logic [CW-1:0]             tgt_col;
   acc_type                   old_acc [3];
   logic signed [16:0]        sx17, sz17, d_sel, mul_a, mul_b;
   comp_type                  prod;

   logic                      norm_start, norm_done;
   comp_type                  norm_vec [3];
   q14_type                   norm_out [3];

   logic                      out_free, em_final;

   // ---------------- configuration ----------------
   assign restart_req = csr_we && (csr_addr == REG_GRID_COLS);

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cols_ff   <= GRID_COLS_RST;
         step_x_ff      <= STEP_X_RST;
         step_z_ff      <= STEP_Z_RST;
         slope_flat_ff  <= SLOPE_FLAT_RST;
         slope_edge_ff  <= SLOPE_EDGE_RST;
         height_low_ff  <= HEIGHT_LOW_RST;
         height_mid_ff  <= HEIGHT_MID_RST;
         height_high_ff <= HEIGHT_HIGH_RST;
      end else if (csr_we) begin
         case (csr_addr)
            REG_GRID_COLS:   grid_cols_ff   <= csr_wdata[5:0];
            REG_STEP_X:      step_x_ff      <= csr_wdata;
            REG_STEP_Z:      step_z_ff      <= csr_wdata;
            REG_SLOPE_FLAT:  slope_flat_ff  <= csr_wdata[14:0];
            REG_SLOPE_EDGE:  slope_edge_ff  <= csr_wdata[14:0];
            REG_HEIGHT_LOW:  height_low_ff  <= csr_wdata;
            REG_HEIGHT_MID:  height_mid_ff  <= csr_wdata;
            REG_HEIGHT_HIGH: height_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- item setup ----------------
   always_comb begin
      if (grid_cols_ff < 6'd2)                      cols_m1 = CW'(1);
      else if ({1'b0, grid_cols_ff} > 7'(MAX_COLS)) cols_m1 = CW'(MAX_COLS - 1);
      else                                          cols_m1 = CW'(grid_cols_ff - 6'd1);
      c_in      = (col_ff > cols_m1) ? '0 : col_ff;
      has_cell  = prev_valid_ff && (c_in != '0);
      top_en_in = prev_valid_ff && ((c_in != '0) || req_ch.last);
      if (req_ch.last)          top_hi_in = cols_m1;
      else if (c_in == cols_m1) top_hi_in = c_in;
      else                      top_hi_in = c_in - CW'(1);
      k_in      = (top_en_in && c_in != '0) ? c_in - CW'(1) : '0;
      prev_row  = (row_ff == '0) ? RW'(MAX_ROWS - 1) : row_ff - RW'(1);
   end

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;

   // ---------------- face products ----------------
   always_comb begin
      sx17 = 17'(signed'({1'b0, step_x_ff}));
      sz17 = 17'(signed'({1'b0, step_z_ff}));
      case ({fi_ff, ci_ff == 2'd2})
         2'b00:   d_sel = 17'(tl_ff) - 17'(bl_ff);
         2'b01:   d_sel = 17'(tl_ff) - 17'(tr_ff);
         2'b10:   d_sel = 17'(tr_ff) - 17'(h_ff);
         default: d_sel = 17'(bl_ff) - 17'(h_ff);
      endcase
      mul_a = (ci_ff == 2'd1) ? -sx17 : d_sel;
      mul_b = (ci_ff == 2'd2) ? sx17 : sz17;
      prod  = mul_a * mul_b;
   end

   // accumulator targets: face one TL, BL, TR; face two TR, BL, BR
   always_comb begin
      tgt_top  = (ti_ff == 2'd0) || (ti_ff == 2'd2 && !fi_ff);
      tgt_line = tgt_top ? sel_ff : ~sel_ff;
      tgt_col  = ((ti_ff == 2'd2) || (ti_ff == 2'd0 && fi_ff)) ? c_ff : c_ff - CW'(1);
      tgt_vld  = acc_vld_ff[tgt_line][tgt_col];
      em_line  = em_bot_ff ? ~sel_ff : sel_ff;
      em_vld   = acc_vld_ff[em_line][k_ff];
      old_acc[0] = acc_rdata[3*ACC_W-1:2*ACC_W];
      old_acc[1] = acc_rdata[2*ACC_W-1:ACC_W];
      old_acc[2] = acc_rdata[ACC_W-1:0];
   end

   // ---------------- memories ----------------
   always_comb begin
      h_we    = accept;
      h_waddr = {~sel_ff, c_in};
      case (state_ff)
         S_RD_TL: h_raddr = {sel_ff, c_ff - CW'(1)};
         S_RD_TR: h_raddr = {sel_ff, c_ff};
         default: h_raddr = {em_line, k_ff};
      endcase
      acc_raddr = (state_ff == S_EM_RD) ? {em_line, k_ff} : {tgt_line, tgt_col};
      acc_waddr = {tgt_line, tgt_col};
      acc_we    = (state_ff == S_ACC_WR);
      acc_wdata = {(tgt_vld ? old_acc[0] : '0) + ACC_W'(norm_out[0]),
                   (tgt_vld ? old_acc[1] : '0) + ACC_W'(norm_out[1]),
                   (tgt_vld ? old_acc[2] : '0) + ACC_W'(norm_out[2])};
   end

   hnc_ram #(.WIDTH(H_W), .DEPTH(DEPTH)) u_height_ram (
      .clock (clock),
      .we    (h_we),
      .waddr (h_waddr),
      .wdata (req_ch.height),
      .raddr (h_raddr),
      .rdata (h_rdata)
   );

   hnc_ram #(.WIDTH(ACC_DW), .DEPTH(DEPTH)) u_acc_ram (
      .clock (clock),
      .we    (acc_we),
      .waddr (acc_waddr),
      .wdata (acc_wdata),
      .raddr (acc_raddr),
      .rdata (acc_rdata)
   );

   // ---------------- normaliser ----------------
   assign norm_start = (state_ff == S_NSTART) || (state_ff == S_EM_LD);
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (state_ff == S_EM_LD) norm_vec[i] = em_vld ? acc_to_comp(old_acc[i]) : '0;
         else                     norm_vec[i] = f_ff[i];
      end
   end

   hnc_norm u_norm (
      .clock    (clock),
      .reset    (reset),
      .start    (norm_start),
      .vec_in   (norm_vec),
      .done     (norm_done),
      .norm_out (norm_out)
   );

   // ---------------- emission ----------------
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign em_final = (em_bot_ff ? (k_ff == c_ff) : (k_ff == top_hi_ff && !last_ff))
                     || (em_cnt_ff == CNT_W'(OUT_LIMIT - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         col_ff        <= '0;
         row_ff        <= '0;
         prev_valid_ff <= 1'b0;
         sel_ff        <= 1'b0;
         acc_vld_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_ch.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  c_ff      <= c_in;
                  last_ff   <= req_ch.last;
                  h_ff      <= req_ch.height;
                  bl_ff     <= h_ff;      // previous sample of this row
                  top_hi_ff <= top_hi_in;
                  k_ff      <= k_in;
                  em_bot_ff <= !top_en_in;
                  em_cnt_ff <= '0;
                  fi_ff     <= 1'b0;
                  ci_ff     <= 2'd0;
                  if (has_cell)                         state_ff <= S_RD_TL;
                  else if (top_en_in || req_ch.last)    state_ff <= S_EM_RD;
                  else                                  state_ff <= S_FIN;
               end
            end
            S_RD_TL:  state_ff <= S_RD_TR;
            S_RD_TR: begin
               tl_ff    <= h_rdata;
               state_ff <= S_GET_TR;
            end
            S_GET_TR: begin
               tr_ff    <= h_rdata;
               state_ff <= S_MUL;
            end
            S_MUL: begin
               f_ff[ci_ff] <= prod;
               if (ci_ff == 2'd2) state_ff <= S_NSTART;
               else               ci_ff    <= ci_ff + 2'd1;
            end
            S_NSTART: state_ff <= S_NWAIT;
            S_NWAIT: begin
               if (norm_done) begin
                  ti_ff    <= 2'd0;
                  state_ff <= S_ACC_RD;
               end
            end
            S_ACC_RD: state_ff <= S_ACC_WR;
            S_ACC_WR: begin
               acc_vld_ff[tgt_line][tgt_col] <= 1'b1;
               if (ti_ff == 2'd2) begin
                  if (!fi_ff) begin
                     fi_ff    <= 1'b1;
                     ci_ff    <= 2'd0;
                     state_ff <= S_MUL;
                  end else begin
                     state_ff <= S_EM_RD;
                  end
               end else begin
                  ti_ff    <= ti_ff + 2'd1;
                  state_ff <= S_ACC_RD;
               end
            end
            S_EM_RD: state_ff <= S_EM_LD;
            S_EM_LD: begin
               eh_ff    <= h_rdata;
               state_ff <= S_EM_WAIT;
            end
            S_EM_WAIT: begin
               if (norm_done) state_ff <= S_EM_OUT;
            end
            S_EM_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_nx_ff    <= norm_out[0];
                  rsp_ny_ff    <= norm_out[1];
                  rsp_nz_ff    <= norm_out[2];
                  rsp_cls_ff   <= classify(norm_out[1], eh_ff, slope_flat_ff, slope_edge_ff,
                                           height_low_ff, height_mid_ff, height_high_ff);
                  rsp_row_ff   <= ROW_W'(em_bot_ff ? row_ff : prev_row);
                  rsp_col_ff   <= COL_W'(k_ff);
                  rsp_last_ff  <= last_ff && em_final;
                  em_cnt_ff    <= em_cnt_ff + CNT_W'(1);
                  if (em_final) begin
                     state_ff <= S_FIN;
                  end else begin
                     if (!em_bot_ff && k_ff == top_hi_ff) begin
                        em_bot_ff <= 1'b1;
                        k_ff      <= '0;
                     end else begin
                        k_ff <= k_ff + CW'(1);
                     end
                     state_ff <= S_EM_RD;
                  end
               end
            end
            S_FIN: begin
               if (last_ff) begin
                  col_ff        <= '0;
                  row_ff        <= '0;
                  prev_valid_ff <= 1'b0;
                  acc_vld_ff    <= '0;
               end else if (c_ff == cols_m1) begin
                  // row done: old top line becomes the new bottom line, cleared
                  acc_vld_ff[sel_ff] <= '0;
                  sel_ff             <= ~sel_ff;
                  prev_valid_ff      <= 1'b1;
                  row_ff             <= (row_ff == RW'(MAX_ROWS - 1)) ? '0 : row_ff + RW'(1);
                  col_ff             <= '0;
               end else begin
                  col_ff <= c_ff + CW'(1);
               end
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
         if (restart_req) begin
            col_ff        <= '0;
            row_ff        <= '0;
            prev_valid_ff <= 1'b0;
            acc_vld_ff    <= '0;
         end
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.normal_x     = rsp_nx_ff;
   assign rsp_ch.normal_y     = rsp_ny_ff;
   assign rsp_ch.normal_z     = rsp_nz_ff;
   assign rsp_ch.vertex_class = rsp_cls_ff;
   assign rsp_ch.row          = rsp_row_ff;
   assign rsp_ch.col          = rsp_col_ff;
   assign rsp_ch.last_out     = rsp_last_ff;
endmodule
